// ----- sv/delq_pkg.sv -----
// Shared types and constants for the delayed event queue.
package delq_pkg;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned COUNT_W = 7;

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH_READY,
    OP_PUSH_WAIT,
    OP_POP,
    OP_TICK,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [ID_W-1:0]    event_id;
    logic [DELAY_W-1:0] delay;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]    event_id;
    logic [DELAY_W-1:0] delay;
  } wait_entry_t;

  typedef struct packed {
    logic               ok;
    logic [ID_W-1:0]    out_event_id;
    logic [COUNT_W-1:0] moved_count;
    logic [COUNT_W-1:0] dropped_count;
    logic [COUNT_W-1:0] ready_count;
    logic [COUNT_W-1:0] waiting_count;
  } rsp_t;

endpackage

// ----- sv/delq_ifs.sv -----
// Request and response channel interfaces of the delayed event queue.
interface delq_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [delq_pkg::ID_W-1:0]    event_id;
  logic [delq_pkg::DELAY_W-1:0] delay;

  modport source (output valid, req_type, event_id, delay, input ready);
  modport sink (input valid, req_type, event_id, delay, output ready);
endinterface

interface delq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [delq_pkg::ID_W-1:0]    out_event_id;
  logic [delq_pkg::COUNT_W-1:0] moved_count;
  logic [delq_pkg::COUNT_W-1:0] dropped_count;
  logic [delq_pkg::COUNT_W-1:0] ready_count;
  logic [delq_pkg::COUNT_W-1:0] waiting_count;

  modport source (output valid, ok, out_event_id, moved_count, dropped_count, ready_count,
                  waiting_count, input ready);
  modport sink (input valid, ok, out_event_id, moved_count, dropped_count, ready_count,
                waiting_count, output ready);
endinterface

// ----- sv/delq_front.sv -----
// Front end: accepts request transactions, decodes them and queues commands.
module delq_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  delq_req_if.sink       req_i,
  output delq_pkg::cmd_t cmd_o,
  output logic           cmd_valid_o,
  input  logic           cmd_pop_i
);

  delq_pkg::cmd_t slot_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;
  delq_pkg::cmd_t cls;
  logic           push;
  logic           pop;

  always_comb begin
    cls.event_id = req_i.event_id;
    cls.delay    = req_i.delay;
    unique case (req_i.req_type)
      delq_pkg::REQ_PUSH: begin
        cls.op = (req_i.delay == '0) ? delq_pkg::OP_PUSH_READY : delq_pkg::OP_PUSH_WAIT;
      end
      delq_pkg::REQ_POP:  cls.op = delq_pkg::OP_POP;
      delq_pkg::REQ_TICK: cls.op = delq_pkg::OP_TICK;
      default:            cls.op = delq_pkg::OP_NOP;
    endcase
  end

  assign req_i.ready = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = req_i.valid && req_i.ready;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ----- sv/delq_back.sv -----
// Back end: ready and waiting ring memories, command sequencer and result register.
module delq_back #(
  parameter int unsigned READY_DEPTH   = 64,
  parameter int unsigned WAITING_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  delq_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  delq_rsp_if.source     rsp_o
);

  localparam int unsigned RAW = $clog2(READY_DEPTH);
  localparam int unsigned RCW = $clog2(READY_DEPTH + 1);
  localparam int unsigned WAW = $clog2(WAITING_DEPTH);
  localparam int unsigned WCW = $clog2(WAITING_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_TICK
  } state_e;

  logic [delq_pkg::ID_W-1:0] ready_mem [READY_DEPTH];
  delq_pkg::wait_entry_t     waiting_mem [WAITING_DEPTH];

  state_e                       state_q, state_d;
  logic [RAW-1:0]               r_head_q, r_head_d, r_tail_q, r_tail_d;
  logic [RCW-1:0]               r_fill_q, r_fill_d;
  logic [WAW-1:0]               w_head_q, w_head_d, w_tail_q, w_tail_d;
  logic [WCW-1:0]               w_fill_q, w_fill_d;
  logic [WCW-1:0]               walk_left_q, walk_left_d;
  logic                         pend_q, pend_d;
  logic [delq_pkg::COUNT_W-1:0] moved_q, moved_d, dropped_q, dropped_d;
  logic                         res_valid_q, res_valid_d;
  delq_pkg::rsp_t               res_q, res_d;

  logic                      r_we, r_re, w_we, w_re;
  logic [delq_pkg::ID_W-1:0] r_wdata;
  delq_pkg::wait_entry_t     w_wdata;
  logic [delq_pkg::ID_W-1:0] r_rdata_q;
  delq_pkg::wait_entry_t     w_rdata_q;
  logic                      slot_free;

  function automatic logic [RAW-1:0] r_next(input logic [RAW-1:0] p);
    return (p == RAW'(READY_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [WAW-1:0] w_next(input logic [WAW-1:0] p);
    return (p == WAW'(WAITING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign slot_free = !res_valid_q || rsp_o.ready;

  always_comb begin
    state_d     = state_q;
    r_head_d    = r_head_q;
    r_tail_d    = r_tail_q;
    r_fill_d    = r_fill_q;
    w_head_d    = w_head_q;
    w_tail_d    = w_tail_q;
    w_fill_d    = w_fill_q;
    walk_left_d = walk_left_q;
    pend_d      = pend_q;
    moved_d     = moved_q;
    dropped_d   = dropped_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !rsp_o.ready;
    cmd_pop_o   = 1'b0;
    r_we        = 1'b0;
    r_re        = 1'b0;
    w_we        = 1'b0;
    w_re        = 1'b0;
    r_wdata     = cmd_i.event_id;
    w_wdata     = {cmd_i.event_id, cmd_i.delay};

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          cmd_pop_o           = 1'b1;
          res_d.ok            = 1'b0;
          res_d.out_event_id  = '0;
          res_d.moved_count   = '0;
          res_d.dropped_count = '0;
          case (cmd_i.op)
            delq_pkg::OP_PUSH_READY: begin
              if (r_fill_q != RCW'(READY_DEPTH)) begin
                r_we     = 1'b1;
                r_tail_d = r_next(r_tail_q);
                r_fill_d = r_fill_q + 1'b1;
                res_d.ok = 1'b1;
              end
            end
            delq_pkg::OP_PUSH_WAIT: begin
              if (w_fill_q != WCW'(WAITING_DEPTH)) begin
                w_we     = 1'b1;
                w_tail_d = w_next(w_tail_q);
                w_fill_d = w_fill_q + 1'b1;
                res_d.ok = 1'b1;
              end
            end
            delq_pkg::OP_POP: begin
              if (r_fill_q != '0) begin
                r_re     = 1'b1;
                r_head_d = r_next(r_head_q);
                r_fill_d = r_fill_q - 1'b1;
                state_d  = ST_POP;
              end
            end
            delq_pkg::OP_TICK: begin
              walk_left_d = w_fill_q;
              pend_d      = 1'b0;
              moved_d     = '0;
              dropped_d   = '0;
              state_d     = ST_TICK;
            end
            default: begin
            end
          endcase
          res_d.ready_count   = delq_pkg::COUNT_W'(r_fill_d);
          res_d.waiting_count = delq_pkg::COUNT_W'(w_fill_d);
          res_valid_d         = (state_d == ST_IDLE);
        end
      end
      ST_POP: begin
        res_d.ok            = 1'b1;
        res_d.out_event_id  = r_rdata_q;
        res_d.moved_count   = '0;
        res_d.dropped_count = '0;
        res_d.ready_count   = delq_pkg::COUNT_W'(r_fill_q);
        res_d.waiting_count = delq_pkg::COUNT_W'(w_fill_q);
        res_valid_d         = 1'b1;
        state_d             = ST_IDLE;
      end
      ST_TICK: begin
        r_wdata = w_rdata_q.event_id;
        w_wdata = {w_rdata_q.event_id, w_rdata_q.delay - 1'b1};
        if (pend_q) begin
          if (w_rdata_q.delay == '0) begin
            if (r_fill_q != RCW'(READY_DEPTH)) begin
              r_we     = 1'b1;
              r_tail_d = r_next(r_tail_q);
              r_fill_d = r_fill_q + 1'b1;
              moved_d  = moved_q + 1'b1;
            end else begin
              dropped_d = dropped_q + 1'b1;
            end
          end else begin
            w_we     = 1'b1;
            w_tail_d = w_next(w_tail_q);
          end
        end
        if (walk_left_q != '0) begin
          w_re        = 1'b1;
          w_head_d    = w_next(w_head_q);
          walk_left_d = walk_left_q - 1'b1;
          pend_d      = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        w_fill_d = w_fill_q - {{(WCW-1){1'b0}}, w_re} + {{(WCW-1){1'b0}}, w_we};
        if (!pend_q && walk_left_q == '0) begin
          res_d.ok            = 1'b1;
          res_d.out_event_id  = '0;
          res_d.moved_count   = moved_q;
          res_d.dropped_count = dropped_q;
          res_d.ready_count   = delq_pkg::COUNT_W'(r_fill_q);
          res_d.waiting_count = delq_pkg::COUNT_W'(w_fill_q);
          res_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      r_head_q    <= '0;
      r_tail_q    <= '0;
      r_fill_q    <= '0;
      w_head_q    <= '0;
      w_tail_q    <= '0;
      w_fill_q    <= '0;
      walk_left_q <= '0;
      pend_q      <= 1'b0;
      moved_q     <= '0;
      dropped_q   <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      r_head_q    <= r_head_d;
      r_tail_q    <= r_tail_d;
      r_fill_q    <= r_fill_d;
      w_head_q    <= w_head_d;
      w_tail_q    <= w_tail_d;
      w_fill_q    <= w_fill_d;
      walk_left_q <= walk_left_d;
      pend_q      <= pend_d;
      moved_q     <= moved_d;
      dropped_q   <= dropped_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_we) begin
      ready_mem[r_tail_q] <= r_wdata;
    end
    if (r_re) begin
      r_rdata_q <= ready_mem[r_head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      waiting_mem[w_tail_q] <= w_wdata;
    end
    if (w_re) begin
      w_rdata_q <= waiting_mem[w_head_q];
    end
  end

  assign rsp_o.valid         = res_valid_q;
  assign rsp_o.ok            = res_q.ok;
  assign rsp_o.out_event_id  = res_q.out_event_id;
  assign rsp_o.moved_count   = res_q.moved_count;
  assign rsp_o.dropped_count = res_q.dropped_count;
  assign rsp_o.ready_count   = res_q.ready_count;
  assign rsp_o.waiting_count = res_q.waiting_count;

endmodule

// ----- sv/delayed_event_queue.sv -----
// Top level of the delayed event queue: command front end feeding the queue back end.
// A push, a failed pop or an unused request passes through the front end command slots
// and the back end result register; a pop that returns an event also passes through the
// ready memory read register and the pop state, and a tick reads each waiting entry once.
// Throughput: one push per cycle while responses are accepted; a returning pop or a tick
// holds the back end, which takes no new command until that response is registered.
module delayed_event_queue #(
  parameter int unsigned READY_DEPTH   = 64,
  parameter int unsigned WAITING_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  delq_req_if.sink   req_i,
  delq_rsp_if.source rsp_o
);

  delq_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;

  delq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cmd_o      (cmd),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop)
  );

  delq_back #(
    .READY_DEPTH  (READY_DEPTH),
    .WAITING_DEPTH(WAITING_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .rsp_o      (rsp_o)
  );

endmodule

// ----- tb/sv/delq_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts every response of the delayed event queue and compares it.
module delq_checker #(
  parameter int unsigned READY_DEPTH   = 64,
  parameter int unsigned WAITING_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  delq_req_if  req_i,
  delq_rsp_if  rsp_i,
  output int   err_count_o,
  output int   pending_o,
  output int   moved_total_o,
  output int   dropped_total_o,
  output int   rejected_total_o
);

  logic [delq_pkg::ID_W-1:0] rdy_mem [READY_DEPTH];
  delq_pkg::wait_entry_t     wt_mem  [WAITING_DEPTH];
  int unsigned               rdy_rd, rdy_wr, rdy_cnt;
  int unsigned               wt_rd, wt_wr, wt_cnt;

  delq_pkg::rsp_t pending_rsp_q[$];
  delq_pkg::rsp_t want;
  int             err_count, pending_n, moved_total, dropped_total, rejected_total;

  assign err_count_o      = err_count;
  assign pending_o        = pending_n;
  assign moved_total_o    = moved_total;
  assign dropped_total_o  = dropped_total;
  assign rejected_total_o = rejected_total;

  function automatic int unsigned ring_step(int unsigned idx, int unsigned depth);
    return (idx + 1 >= depth) ? 0 : idx + 1;
  endfunction

  function automatic bit ready_append(logic [delq_pkg::ID_W-1:0] id);
    if (rdy_cnt >= READY_DEPTH) return 1'b0;
    rdy_mem[rdy_wr] = id;
    rdy_wr = ring_step(rdy_wr, READY_DEPTH);
    rdy_cnt++;
    return 1'b1;
  endfunction

  function automatic bit waiting_append(delq_pkg::wait_entry_t ent);
    if (wt_cnt >= WAITING_DEPTH) return 1'b0;
    wt_mem[wt_wr] = ent;
    wt_wr = ring_step(wt_wr, WAITING_DEPTH);
    wt_cnt++;
    return 1'b1;
  endfunction

  function automatic delq_pkg::rsp_t serve_request(logic [1:0] kind,
                                                   logic [delq_pkg::ID_W-1:0] id,
                                                   logic [delq_pkg::DELAY_W-1:0] dly);
    delq_pkg::rsp_t        r;
    delq_pkg::wait_entry_t ent;
    int unsigned           n;
    int unsigned           moved;
    int unsigned           dropped;
    r       = '0;
    moved   = 0;
    dropped = 0;
    case (kind)
      delq_pkg::REQ_PUSH: begin
        ent.event_id = id;
        ent.delay    = dly;
        r.ok = (dly == '0) ? ready_append(id) : waiting_append(ent);
        if (!r.ok) rejected_total++;
      end
      delq_pkg::REQ_POP: begin
        if (rdy_cnt != 0) begin
          r.ok           = 1'b1;
          r.out_event_id = rdy_mem[rdy_rd];
          rdy_rd         = ring_step(rdy_rd, READY_DEPTH);
          rdy_cnt--;
        end
      end
      delq_pkg::REQ_TICK: begin
        n = wt_cnt;
        for (int unsigned i = 0; i < n; i++) begin
          ent   = wt_mem[wt_rd];
          wt_rd = ring_step(wt_rd, WAITING_DEPTH);
          wt_cnt--;
          if (ent.delay == '0) begin
            if (ready_append(ent.event_id)) moved++;
            else dropped++;
          end else begin
            ent.delay = ent.delay - 1'b1;
            void'(waiting_append(ent));
          end
        end
        r.ok = 1'b1;
        moved_total   += moved;
        dropped_total += dropped;
      end
      default: ;
    endcase
    r.moved_count   = delq_pkg::COUNT_W'(moved);
    r.dropped_count = delq_pkg::COUNT_W'(dropped);
    r.ready_count   = delq_pkg::COUNT_W'(rdy_cnt);
    r.waiting_count = delq_pkg::COUNT_W'(wt_cnt);
    return r;
  endfunction

  function automatic void check_field(string name, logic [delq_pkg::ID_W-1:0] exp_v,
                                      logic [delq_pkg::ID_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy_rd         <= 0;
      rdy_wr         <= 0;
      rdy_cnt        <= 0;
      wt_rd          <= 0;
      wt_wr          <= 0;
      wt_cnt         <= 0;
      err_count      <= 0;
      pending_n      <= 0;
      moved_total    <= 0;
      dropped_total  <= 0;
      rejected_total <= 0;
      pending_rsp_q.delete();
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_rsp_q.size() == 0) begin
          $error("Response transaction arrived with no request outstanding.");
          err_count++;
        end else begin
          want = pending_rsp_q.pop_front();
          check_field("ok", delq_pkg::ID_W'(want.ok), delq_pkg::ID_W'(rsp_i.ok));
          check_field("out_event_id", want.out_event_id, rsp_i.out_event_id);
          check_field("moved_count", delq_pkg::ID_W'(want.moved_count),
                      delq_pkg::ID_W'(rsp_i.moved_count));
          check_field("dropped_count", delq_pkg::ID_W'(want.dropped_count),
                      delq_pkg::ID_W'(rsp_i.dropped_count));
          check_field("ready_count", delq_pkg::ID_W'(want.ready_count),
                      delq_pkg::ID_W'(rsp_i.ready_count));
          check_field("waiting_count", delq_pkg::ID_W'(want.waiting_count),
                      delq_pkg::ID_W'(rsp_i.waiting_count));
        end
      end
      if (req_i.valid && req_i.ready) begin
        pending_rsp_q.push_back(serve_request(req_i.req_type, req_i.event_id, req_i.delay));
      end
      pending_n <= pending_rsp_q.size();
    end
  end

endmodule

// ----- tb/sv/delayed_event_queue_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the delayed event queue: stimulus, response flow control and verdict.
module delayed_event_queue_tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int         N_ITEMS    = 1150;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_TICK, MIX_NOISE} mix_e;

  logic clk;
  logic rst_n;
  bit   calm;
  int   err_count, pending, moved_total, dropped_total, rejected_total;
  int   n_push, n_pop, n_tick, n_unused;

  delq_req_if req_if ();
  delq_rsp_if rsp_if ();

  delayed_event_queue uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  delq_checker chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .req_i           (req_if),
    .rsp_i           (rsp_if),
    .err_count_o     (err_count),
    .pending_o       (pending),
    .moved_total_o   (moved_total),
    .dropped_total_o (dropped_total),
    .rejected_total_o(rejected_total)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic logic [delq_pkg::DELAY_W-1:0] pick_delay();
    int r = $urandom_range(0, 99);
    if (r < 45) return '0;
    if (r < 80) return delq_pkg::DELAY_W'($urandom_range(1, 3));
    if (r < 95) return delq_pkg::DELAY_W'($urandom_range(4, 20));
    return delq_pkg::DELAY_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [1:0] pick_req(mix_e mix);
    int r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  return (r < 70) ? delq_pkg::REQ_PUSH : (r < 90) ? delq_pkg::REQ_TICK :
                                   delq_pkg::REQ_POP;
      MIX_DRAIN: return (r < 60) ? delq_pkg::REQ_POP : (r < 90) ? delq_pkg::REQ_TICK :
                                   delq_pkg::REQ_PUSH;
      MIX_TICK:  return (r < 50) ? delq_pkg::REQ_TICK : (r < 90) ? delq_pkg::REQ_PUSH :
                                   delq_pkg::REQ_POP;
      default:   return 2'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic send_request(logic [1:0] kind, logic [delq_pkg::ID_W-1:0] id,
                              logic [delq_pkg::DELAY_W-1:0] dly);
    int gap = draw_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.event_id <= id;
    req_if.delay    <= dly;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
    case (kind)
      delq_pkg::REQ_PUSH: n_push++;
      delq_pkg::REQ_POP:  n_pop++;
      delq_pkg::REQ_TICK: n_tick++;
      default:            n_unused++;
    endcase
  endtask

  initial begin
    int gap;
    rsp_if.ready <= 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      @(negedge clk);
    end
  end

  initial begin
    #4ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    mix_e mix;
    int   run_len;
    int   done;
    logic [1:0] kind;
    req_if.valid    <= 1'b0;
    req_if.req_type <= delq_pkg::REQ_PUSH;
    req_if.event_id <= '0;
    req_if.delay    <= '0;
    rst_n = 1'b0;
    calm  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_request(delq_pkg::REQ_POP, '0, '0);
    send_request(delq_pkg::REQ_TICK, '0, '0);
    send_request(REQ_UNUSED, '1, '1);
    send_request(delq_pkg::REQ_PUSH, '0, '0);
    send_request(delq_pkg::REQ_PUSH, '1, '0);
    send_request(delq_pkg::REQ_PUSH, 32'hA5A5_A5A5, '1);
    send_request(delq_pkg::REQ_PUSH, 32'h5A5A_5A5A, 16'd1);
    send_request(delq_pkg::REQ_PUSH, 32'h0000_FFFF, 16'h8000);
    send_request(delq_pkg::REQ_PUSH, 32'hFFFF_0000, 16'h7FFF);
    send_request(delq_pkg::REQ_TICK, '0, '0);
    send_request(delq_pkg::REQ_TICK, '1, '1);
    send_request(delq_pkg::REQ_POP, '1, '1);
    send_request(delq_pkg::REQ_POP, '0, '0);
    send_request(delq_pkg::REQ_POP, '0, '0);
    send_request(delq_pkg::REQ_POP, '0, '0);
    send_request(REQ_UNUSED, '0, '0);
    send_request(delq_pkg::REQ_PUSH, 32'h1234_5678, 16'd2);
    send_request(delq_pkg::REQ_TICK, '0, '0);
    send_request(delq_pkg::REQ_TICK, '0, '0);
    send_request(delq_pkg::REQ_TICK, '0, '0);
    send_request(delq_pkg::REQ_POP, '0, '0);

    done = 0;
    while (done < N_ITEMS) begin
      mix     = mix_e'($urandom_range(0, 3));
      run_len = $urandom_range(20, 150);
      calm    = ($urandom_range(0, 3) == 0);
      repeat (run_len) begin
        if (done < N_ITEMS) begin
          kind = pick_req(mix);
          send_request(kind, $urandom(), (kind == delq_pkg::REQ_PUSH) ? pick_delay() :
                                         delq_pkg::DELAY_W'($urandom_range(0, 65535)));
          done++;
        end
      end
    end
    req_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d push, %0d pop, %0d tick and %0d unused requests; %0d pushes refused.",
             n_push, n_pop, n_tick, n_unused, rejected_total);
    $display("Ticks moved %0d events to the ready queue and dropped %0d.",
             moved_total, dropped_total);
    if (err_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- delayed_event_queue.f -----
sv/delq_pkg.sv
sv/delq_ifs.sv
sv/delq_front.sv
sv/delq_back.sv
sv/delayed_event_queue.sv
tb/sv/delq_checker.sv
tb/sv/delayed_event_queue_tb.sv
